/* src/fpmds_pkg.sv */
// Shared types, constants and codes for the fixed-point multiply, divide and square root unit.
package fpmds_pkg;

  // Word and fraction widths of the raw fixed-point values.
  localparam int W = 32;
  localparam int F = 16;
  localparam int SH = F / 2;

  // Square root works on bit pairs; the root has one bit per pair.
  localparam int SQ_ITER = (W + 1) / 2;
  localparam int RW = SQ_ITER;

  // Width of the wide work register: big enough for a shifted product or a quotient.
  localparam int QW = (2 * W - F > W + F) ? 2 * W - F : W + F;
  localparam int CW = $clog2(QW);

  localparam logic [W-1:0] WMAXP = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] WSIGN = {1'b1, {(W - 1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_MUL,
    MODE_DIV,
    MODE_SQRT,
    MODE_NONE
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SAT,
    ST_DIVZ,
    ST_NEGSQ
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAGA,
    S_MAGB,
    S_RUN,
    S_ROUND,
    S_PACK
  } state_e;

  typedef struct packed {
    logic [1:0]            mode;
    logic signed [W-1:0]   operand_a;
    logic signed [W-1:0]   operand_b;
  } req_t;

  typedef struct packed {
    logic signed [W-1:0]   result;
    logic [1:0]            status;
  } rsp_t;

  // Sequencer to datapath: current step and output register load.
  typedef struct packed {
    state_e step;
    logic   out_load;
  } ctl_t;

  // Datapath to sequencer: latched operation and early-out flag.
  typedef struct packed {
    mode_e mode;
    logic  special;
  } dp_stat_t;

endpackage

/* src/fpmds_addsub.sv */
// Shared add/subtract unit used by every step of the datapath.
module fpmds_addsub (
  input  logic [fpmds_pkg::QW-1:0] a,
  input  logic [fpmds_pkg::QW-1:0] b,
  input  logic                     sub,
  output logic [fpmds_pkg::QW-1:0] sum,
  output logic                     carry
);

  logic [fpmds_pkg::QW:0] total;

  // On subtract, a carry out means a >= b (no borrow).
  assign total = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{fpmds_pkg::QW{1'b0}}, sub};
  assign sum   = total[fpmds_pkg::QW-1:0];
  assign carry = total[fpmds_pkg::QW];

endmodule

/* src/fpmds_seq.sv */
// Sequencer: steps one operation through sign removal, iterations, rounding and packing.
module fpmds_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_fire,
  input  fpmds_pkg::dp_stat_t stat,
  input  logic                out_free,
  output logic                idle,
  output fpmds_pkg::ctl_t     ctl
);

  fpmds_pkg::state_e         state;
  fpmds_pkg::state_e         state_next;
  logic [fpmds_pkg::CW-1:0]  cnt;
  logic [fpmds_pkg::CW-1:0]  cnt_next;

  // State and iteration counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpmds_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state and step control.
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    ctl.step     = state;
    ctl.out_load = 1'b0;
    idle         = (state == fpmds_pkg::S_IDLE);
    case (state)
      fpmds_pkg::S_IDLE: begin
        if (req_fire) begin
          state_next = fpmds_pkg::S_MAGA;
        end
      end
      fpmds_pkg::S_MAGA: begin
        state_next = stat.special ? fpmds_pkg::S_PACK : fpmds_pkg::S_MAGB;
      end
      fpmds_pkg::S_MAGB: begin
        state_next = fpmds_pkg::S_RUN;
        case (stat.mode)
          fpmds_pkg::MODE_MUL: cnt_next = fpmds_pkg::CW'(fpmds_pkg::W - 1);
          fpmds_pkg::MODE_DIV: cnt_next = fpmds_pkg::CW'(fpmds_pkg::QW - 1);
          default:             cnt_next = fpmds_pkg::CW'(fpmds_pkg::SQ_ITER - 1);
        endcase
      end
      fpmds_pkg::S_RUN: begin
        if (cnt == '0) begin
          state_next = fpmds_pkg::S_ROUND;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      fpmds_pkg::S_ROUND: begin
        state_next = fpmds_pkg::S_PACK;
      end
      fpmds_pkg::S_PACK: begin
        // Hold the finished value until the output register is free.
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_next   = fpmds_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fpmds_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* src/fpmds_dp.sv */
// Datapath: operand registers, work registers and the steps that share one adder.
module fpmds_dp (
  input  logic                clk,
  input  fpmds_pkg::req_t     req,
  input  logic                load,
  input  fpmds_pkg::ctl_t     ctl,
  output fpmds_pkg::dp_stat_t stat,
  output fpmds_pkg::rsp_t     pack_out
);

  localparam int W  = fpmds_pkg::W;
  localparam int QW = fpmds_pkg::QW;
  localparam int RW = fpmds_pkg::RW;

  fpmds_pkg::mode_e   mode;
  fpmds_pkg::status_e spec_status;
  logic               special;
  logic               na;
  logic               nb;
  logic               neg;
  logic [W-1:0]       ma;
  logic [W-1:0]       mb;
  logic [W-1:0]       hi;
  logic [QW-1:0]      lo;
  logic [RW-1:0]      root;

  logic [QW-1:0]      add_a;
  logic [QW-1:0]      add_b;
  logic               add_sub;
  logic [QW-1:0]      sum;
  logic               carry;

  logic [W-1:0]       div_sh;
  logic [RW+1:0]      sq_sh;
  logic [RW+1:0]      sq_trial;
  logic [2*W-1:0]     prod;
  logic [QW-1:0]      q_src;
  logic               round_inc;
  logic               sat;
  logic               is_divz;
  logic               is_negsq;

  // Partial remainders with the next dividend bit or radicand pair shifted in.
  // Only a negative product with discarded fraction bits moves one step away from zero.
  assign div_sh    = {hi[W-2:0], lo[QW-1]};
  assign sq_sh     = {hi[RW-1:0], lo[QW-1:QW-2]};
  assign sq_trial  = {root, 2'b01};
  assign prod      = {hi, mb};
  assign round_inc = neg & (mode == fpmds_pkg::MODE_MUL) & (|mb[fpmds_pkg::F-1:0]);

  // Magnitude before sign and saturation, per operation.
  always_comb begin
    case (mode)
      fpmds_pkg::MODE_MUL:  q_src = QW'(prod >> fpmds_pkg::F);
      fpmds_pkg::MODE_DIV:  q_src = lo;
      fpmds_pkg::MODE_SQRT: q_src = QW'(root) << fpmds_pkg::SH;
      default:              q_src = '0;
    endcase
  end

  // Operand selection for the shared adder.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (ctl.step)
      fpmds_pkg::S_MAGA: begin
        add_a   = na ? '0 : QW'(ma);
        add_b   = na ? QW'(ma) : '0;
        add_sub = na;
      end
      fpmds_pkg::S_MAGB: begin
        add_a   = nb ? '0 : QW'(mb);
        add_b   = nb ? QW'(mb) : '0;
        add_sub = nb;
      end
      fpmds_pkg::S_RUN: begin
        case (mode)
          fpmds_pkg::MODE_MUL: begin
            add_a = QW'(hi);
            add_b = mb[0] ? QW'(ma) : '0;
          end
          fpmds_pkg::MODE_DIV: begin
            add_a   = QW'(div_sh);
            add_b   = QW'(mb);
            add_sub = 1'b1;
          end
          default: begin
            add_a   = QW'(sq_sh);
            add_b   = QW'(sq_trial);
            add_sub = 1'b1;
          end
        endcase
      end
      fpmds_pkg::S_ROUND: begin
        add_a = q_src;
        add_b = QW'(round_inc);
      end
      fpmds_pkg::S_PACK: begin
        add_a   = neg ? '0 : lo;
        add_b   = neg ? lo : '0;
        add_sub = neg;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  fpmds_addsub u_addsub (
    .a     (add_a),
    .b     (add_b),
    .sub   (add_sub),
    .sum   (sum),
    .carry (carry)
  );

  // Cases that finish without iterating.
  assign is_divz  = (req.mode == fpmds_pkg::MODE_DIV) && (req.operand_b == '0);
  assign is_negsq = (req.mode == fpmds_pkg::MODE_SQRT) && req.operand_a[W-1];

  // Work registers; each step updates only what it owns.
  always_ff @(posedge clk) begin
    if (load) begin
      mode    <= fpmds_pkg::mode_e'(req.mode);
      ma      <= req.operand_a;
      mb      <= req.operand_b;
      na      <= req.operand_a[W-1];
      nb      <= req.operand_b[W-1];
      neg     <= ((req.mode == fpmds_pkg::MODE_MUL) || (req.mode == fpmds_pkg::MODE_DIV)) &&
                 (req.operand_a[W-1] ^ req.operand_b[W-1]);
      hi      <= '0;
      root    <= '0;
      special <= is_divz || is_negsq || (req.mode == fpmds_pkg::MODE_NONE);
      if (is_divz) begin
        spec_status <= fpmds_pkg::ST_DIVZ;
      end else if (is_negsq) begin
        spec_status <= fpmds_pkg::ST_NEGSQ;
      end else begin
        spec_status <= fpmds_pkg::ST_OK;
      end
    end else begin
      case (ctl.step)
        fpmds_pkg::S_MAGA: begin
          ma <= sum[W-1:0];
          // Divide shifts the dividend up by the fraction bits; the radicand is
          // aligned so that its bit pairs leave from the top.
          if (mode == fpmds_pkg::MODE_DIV) begin
            lo <= QW'(sum[W-1:0]) << fpmds_pkg::F;
          end else begin
            lo <= QW'(sum[W-1:0]) << (QW - 2 * fpmds_pkg::SQ_ITER);
          end
        end
        fpmds_pkg::S_MAGB: begin
          mb <= sum[W-1:0];
        end
        fpmds_pkg::S_RUN: begin
          case (mode)
            fpmds_pkg::MODE_MUL: begin
              // Shift-add: the low product bits fill the multiplier register.
              hi <= sum[W:1];
              mb <= {sum[0], mb[W-1:1]};
            end
            fpmds_pkg::MODE_DIV: begin
              // Restoring division, one quotient bit per cycle.
              hi <= carry ? sum[W-1:0] : div_sh;
              lo <= {lo[QW-2:0], carry};
            end
            default: begin
              // Restoring square root, one root bit per cycle.
              hi   <= carry ? W'(sum[RW+1:0]) : W'(sq_sh);
              root <= {root[RW-2:0], carry};
              lo   <= lo << 2;
            end
          endcase
        end
        fpmds_pkg::S_ROUND: begin
          lo <= sum;
        end
        default: begin
          lo <= lo;
        end
      endcase
    end
  end

  // Saturation against the signed range; a negative value may reach the sign weight.
  assign sat = (|lo[QW-1:W]) | (lo[W-1] & ~(neg & ~(|lo[W-2:0])));

  // Final result as seen in the pack step.
  always_comb begin
    if (special) begin
      pack_out.result = (spec_status == fpmds_pkg::ST_NEGSQ) ? '1 : '0;
      pack_out.status = spec_status;
    end else if (sat) begin
      pack_out.result = neg ? fpmds_pkg::WSIGN : fpmds_pkg::WMAXP;
      pack_out.status = fpmds_pkg::ST_SAT;
    end else begin
      pack_out.result = sum[W-1:0];
      pack_out.status = fpmds_pkg::ST_OK;
    end
  end

  assign stat.mode    = mode;
  assign stat.special = special;

endmodule

/* src/fixed_point_mul_div_sqrt.sv */
// Top level of the signed fixed-point multiply, divide and square root unit.
// Each operation passes through sign removal, the iterations on the shared adder, rounding and
// packing; divide by zero, a negative root or the unused mode go straight to packing.
// One operation at a time: a new beat can be taken in the cycle after the result enters
// the output register.
// Reset clears the sequencer and the output valid flag; the datapath holds no reset state.
module fixed_point_mul_div_sqrt (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  fpmds_pkg::req_t  req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output fpmds_pkg::rsp_t  rsp
);

  logic                idle;
  logic                req_fire;
  logic                out_free;
  fpmds_pkg::ctl_t     ctl;
  fpmds_pkg::dp_stat_t stat;
  fpmds_pkg::rsp_t     pack_out;

  assign req_ready = idle;
  assign req_fire  = req_valid & req_ready;
  assign out_free  = ~rsp_valid | rsp_ready;

  fpmds_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_fire (req_fire),
    .stat     (stat),
    .out_free (out_free),
    .idle     (idle),
    .ctl      (ctl)
  );

  fpmds_dp u_dp (
    .clk      (clk),
    .req      (req),
    .load     (req_fire),
    .ctl      (ctl),
    .stat     (stat),
    .pack_out (pack_out)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      rsp <= pack_out;
    end
  end

endmodule

/* src/fpmds_checker.sv */
// Port-level checks for the fixed-point arithmetic unit, bound to the top level.
module fpmds_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input fpmds_pkg::rsp_t rsp
);

  // A stalled result beat keeps its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  // The unit works on one operation at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("input taken again right after an accepted beat");

  // Divide by zero returns zero.
  a_divz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == fpmds_pkg::ST_DIVZ) |-> (rsp.result == '0))
    else $error("divide by zero result is not zero");

  // A negative root operand returns all ones.
  a_negsq_ones: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == fpmds_pkg::ST_NEGSQ) |-> (rsp.result == '1))
    else $error("negative root result is not all ones");

  // A saturated result sits at one end of the range.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == fpmds_pkg::ST_SAT) |->
      (rsp.result == fpmds_pkg::WMAXP) || (rsp.result == fpmds_pkg::WSIGN))
    else $error("saturated result is not a range limit");

endmodule

bind fixed_point_mul_div_sqrt fpmds_checker u_fpmds_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
